// ===== hdl/cdam_pkg.sv =====
`timescale 1ns / 1ps

package cdam_pkg;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_SAMPLE_BITS  = 24;

  localparam int CC_W       = 4;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CC_W-1:0]   CC_RESET   = 4'd2;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  localparam int DIV_RADIX_BITS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 1'b0,
    REG_WIDTH_GAIN    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIX,
    BK_RD,
    BK_MUL,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== hdl/channel_difference_amplify_unit.sv =====
`timescale 1ns / 1ps

// Channel difference amplifier for interleaved audio.
// Input channel: one signed sample per item on in_valid_i / in_stall_o. Samples are
// buffered until a frame of channel_count samples is in; an incomplete frame gives nothing.
// Output channel: one item per channel on out_valid_o / out_stall_i, in channel order,
// mean + gain * (sample - mean), saturated; frame_last_o marks the final item of a frame.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 channel count, 1 gain Q4.12).
// Writing the channel count drops any partial frame. Write only while the block is idle.
// The frame store has two banks: one frame fills while the previous one is processed.
// Input takes an item every cycle until both banks hold complete frames.
// Per frame the back end takes the frame, runs the 4-bit-per-cycle mean divider, fixes
// the sign, then for each result reads the store, multiplies, and adds and saturates.
// A stalled output holds its item; the back end waits, and input stalls once both banks fill.
// Reset empties the frame, channel count 2, gain 4096 (unity); no output is pending.

module channel_difference_amplify_unit import cdam_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          frame_last_o
);

  localparam int IW    = $clog2(MAX_CHANNELS);
  localparam int NW    = $clog2(MAX_CHANNELS + 1);
  localparam int SUMW  = SAMPLE_BITS + IW;
  localparam int JOBW  = 1 + GAIN_W + NW + SUMW;
  localparam int DEPTH = 2 ** (IW + 1);

  logic                   ram_we;
  logic [IW:0]            ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [IW:0]            ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   job_push;
  logic [JOBW-1:0]        job_in;
  logic [JOBW-1:0]        job_out;
  logic                   job_pop;
  queue_stat_t            q_stat;
  bank_rel_t              rel;

  cdam_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .q_stat_i    (q_stat),
    .rel_i       (rel)
  );

  cdam_queue #(
    .WIDTH (JOBW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .pop_i  (job_pop),
    .data_o (job_out),
    .stat_o (q_stat)
  );

  cdam_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cdam_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .q_stat_i     (q_stat),
    .pop_o        (job_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .rel_o        (rel),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .frame_last_o (frame_last_o)
  );

endmodule

// ===== hdl/cdam_ram.sv =====
`timescale 1ns / 1ps

module cdam_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cdam_queue.sv =====
`timescale 1ns / 1ps

module cdam_queue import cdam_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output queue_stat_t      stat_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

  assign data_o       = entry_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule

// ===== hdl/cdam_front.sv =====
`timescale 1ns / 1ps

module cdam_front import cdam_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int IW   = $clog2(MAX_CHANNELS),
  localparam int NW   = $clog2(MAX_CHANNELS + 1),
  localparam int SUMW = SAMPLE_BITS + IW,
  localparam int JOBW = 1 + GAIN_W + NW + SUMW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          ram_we_o,
  output logic [IW:0]                   ram_waddr_o,
  output logic [SAMPLE_BITS-1:0]        ram_wdata_o,
  output logic                          job_push_o,
  output logic [JOBW-1:0]               job_o,
  input  queue_stat_t                   q_stat_i,
  input  bank_rel_t                     rel_i
);

  logic [CC_W-1:0]   cc_q;
  logic [GAIN_W-1:0] gain_q;
  logic [IW-1:0]     fill_q;
  logic [SUMW-1:0]   sum_q;
  logic              bank_q;
  logic [1:0]        busy_q;
  logic [1:0]        busy_d;
  logic [NW-1:0]     n_act;
  logic [NW-1:0]     fill_inc;
  logic [SUMW-1:0]   sum_add;
  logic              accept;
  logic              frame_done;
  logic              wr_cc;
  logic              wr_gain;

  always_comb begin
    if (cc_q == '0) begin
      n_act = NW'(1);
    end else if (int'(cc_q) > MAX_CHANNELS) begin
      n_act = NW'(MAX_CHANNELS);
    end else begin
      n_act = NW'(cc_q);
    end
  end

  assign wr_cc      = cfg_we_i && (cfg_idx_i == REG_CHANNEL_COUNT);
  assign wr_gain    = cfg_we_i && (cfg_idx_i == REG_WIDTH_GAIN);
  assign in_stall_o = busy_q[bank_q] || q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign fill_inc   = NW'(fill_q) + NW'(1);
  assign frame_done = (fill_inc == n_act);
  assign sum_add    = sum_q + {{IW{sample_in_i[SAMPLE_BITS-1]}}, sample_in_i};

  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept && frame_done) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= CC_RESET;
      gain_q <= GAIN_RESET;
      fill_q <= '0;
      sum_q  <= '0;
      bank_q <= 1'b0;
      busy_q <= 2'b00;
    end else begin
      busy_q <= busy_d;
      if (wr_gain) begin
        gain_q <= cfg_data_i[GAIN_W-1:0];
      end
      if (wr_cc) begin
        cc_q   <= cfg_data_i[CC_W-1:0];
        fill_q <= '0;
        sum_q  <= '0;
      end else if (accept) begin
        if (frame_done) begin
          fill_q <= '0;
          sum_q  <= '0;
          bank_q <= ~bank_q;
        end else begin
          fill_q <= fill_q + IW'(1);
          sum_q  <= sum_add;
        end
      end
    end
  end

  assign ram_we_o    = accept;
  assign ram_waddr_o = {bank_q, fill_q};
  assign ram_wdata_o = sample_in_i;
  assign job_push_o  = accept && frame_done;
  assign job_o       = {bank_q, gain_q, n_act, sum_add};

  a_fill_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(fill_q) < n_act)
    else $error("fill count beyond frame length");

  a_push_marks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o |=> busy_q[$past(bank_q)])
    else $error("completed bank not held busy");

endmodule

// ===== hdl/cdam_back.sv =====
`timescale 1ns / 1ps

module cdam_back import cdam_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int IW   = $clog2(MAX_CHANNELS),
  localparam int NW   = $clog2(MAX_CHANNELS + 1),
  localparam int SUMW = SAMPLE_BITS + IW,
  localparam int JOBW = 1 + GAIN_W + NW + SUMW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [JOBW-1:0]               job_i,
  input  queue_stat_t                   q_stat_i,
  output logic                          pop_o,
  output logic                          ram_re_o,
  output logic [IW:0]                   ram_raddr_o,
  input  logic [SAMPLE_BITS-1:0]        ram_rdata_i,
  output bank_rel_t                     rel_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          frame_last_o
);

  localparam int SB      = SAMPLE_BITS;
  localparam int QW      = ((SB + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS) * DIV_RADIX_BITS;
  localparam int DIV_CYC = QW / DIV_RADIX_BITS;
  localparam int CW      = $clog2(DIV_CYC + 1);
  localparam int MW      = SUMW + DIV_RADIX_BITS;
  localparam int PW      = SB + 1 + GAIN_W + 1;
  localparam int HW      = PW - GAIN_FRAC;
  localparam int RW      = HW + 1;

  back_state_e state_q, state_d;

  logic [CW-1:0]     cnt_q;
  logic [IW-1:0]     k_q;
  logic              out_valid_q;
  logic              bank_q;
  logic [GAIN_W-1:0] gain_q;
  logic [NW-1:0]     n_q;
  logic              neg_q;
  logic [NW-1:0]     rem_q;
  logic [QW-1:0]     quo_q;
  logic [SB-1:0]     mean_q;
  logic signed [PW-1:0] prod_q;
  logic [SB-1:0]     out_sample_q;
  logic              out_last_q;

  logic              job_bank;
  logic [GAIN_W-1:0] job_gain;
  logic [NW-1:0]     job_n;
  logic [SUMW-1:0]   job_sum;
  logic [SUMW-1:0]   mag;
  logic [MW-1:0]     magx;
  logic [NW-1:0]     rem_step;
  logic [QW-1:0]     quo_step;
  logic [QW:0]       qx;
  logic [SB-1:0]     mean_fix;
  logic signed [SB:0]     diff;
  logic signed [GAIN_W:0] gain_s;
  logic signed [PW-1:0]   prod_d;
  logic signed [PW-1:0]   shr_full;
  logic [HW-1:0]     shr;
  logic [RW-1:0]     res_sum;
  logic [SB-1:0]     res_sat;
  logic              can_load;
  logic              load_out;
  logic              last_k;

  assign job_bank = job_i[JOBW-1];
  assign job_gain = job_i[JOBW-2 -: GAIN_W];
  assign job_n    = job_i[SUMW+NW-1 -: NW];
  assign job_sum  = job_i[SUMW-1:0];
  assign mag      = job_sum[SUMW-1] ? (~job_sum + SUMW'(1)) : job_sum;
  assign magx     = MW'(mag);

  always_comb begin
    logic [NW:0]   t;
    logic [NW-1:0] r;
    logic [QW-1:0] q;
    r = rem_q;
    q = quo_q;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      t = {r, q[QW-1]};
      q = {q[QW-2:0], 1'b0};
      if (t >= {1'b0, n_q}) begin
        r    = NW'(t - {1'b0, n_q});
        q[0] = 1'b1;
      end else begin
        r = t[NW-1:0];
      end
    end
    rem_step = r;
    quo_step = q;
  end

  assign qx       = {1'b0, quo_q} + (QW+1)'(neg_q && (rem_q != '0));
  assign mean_fix = SB'(neg_q ? (~qx + (QW+1)'(1)) : qx);

  assign diff     = $signed({ram_rdata_i[SB-1], ram_rdata_i}) - $signed({mean_q[SB-1], mean_q});
  assign gain_s   = $signed({1'b0, gain_q});
  assign prod_d   = diff * gain_s;

  assign shr_full = prod_q >>> GAIN_FRAC;
  assign shr      = shr_full[HW-1:0];
  assign res_sum  = {shr[HW-1], shr} + {{(RW-SB){mean_q[SB-1]}}, mean_q};

  always_comb begin
    if ((&res_sum[RW-1:SB-1]) || !(|res_sum[RW-1:SB-1])) begin
      res_sat = res_sum[SB-1:0];
    end else if (res_sum[RW-1]) begin
      res_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  assign can_load = !out_valid_q || !out_stall_i;
  assign last_k   = (NW'(k_q) + NW'(1) == n_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_q == CW'(DIV_CYC - 1)) begin
          state_d = BK_FIX;
        end
      end
      BK_FIX:  state_d = BK_RD;
      BK_RD:   state_d = BK_MUL;
      BK_MUL:  state_d = BK_EMIT;
      BK_EMIT: begin
        if (can_load) begin
          state_d = last_k ? BK_IDLE : BK_RD;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == BK_IDLE) && !q_stat_i.empty;
    ram_re_o    = (state_q == BK_RD);
    ram_raddr_o = {bank_q, k_q};
    load_out    = (state_q == BK_EMIT) && can_load;
    rel_o.valid = load_out && last_k;
    rel_o.bank  = bank_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_IDLE) begin
        cnt_q <= '0;
      end else if (state_q == BK_DIV) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (state_q == BK_FIX) begin
        k_q <= '0;
      end else if (load_out && !last_k) begin
        k_q <= k_q + IW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bank_q <= job_bank;
      gain_q <= job_gain;
      n_q    <= job_n;
      neg_q  <= job_sum[SUMW-1];
      rem_q  <= NW'(magx >> QW);
      quo_q  <= magx[QW-1:0];
    end else if (state_q == BK_DIV) begin
      rem_q <= rem_step;
      quo_q <= quo_step;
    end
    if (state_q == BK_FIX) begin
      mean_q <= mean_fix;
    end
    if (state_q == BK_MUL) begin
      prod_q <= prod_d;
    end
    if (load_out) begin
      out_sample_q <= res_sat;
      out_last_q   <= last_k;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign frame_last_o = out_last_q;

  a_rel_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_o.valid |=> out_valid_o && frame_last_o)
    else $error("bank released without last item");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (cnt_q < CW'(DIV_CYC)))
    else $error("divider ran past its step count");

  a_pop_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == BK_DIV))
    else $error("job taken without division");

endmodule

// ===== bench/channel_difference_amplify_unit_tb.sv =====
`timescale 1ns / 1ps

module channel_difference_amplify_unit_tb;
  import cdam_pkg::*;

  localparam int SB = DEF_SAMPLE_BITS;
  localparam int MAX_CH = DEF_MAX_CHANNELS;
  localparam int RANDOM_ITEMS = 240;
  localparam int REST_CYCLES = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam longint L_MAX = (64'sd1 <<< (SB-1)) - 1;
  localparam longint L_MIN = -L_MAX - 1;

  typedef struct packed {
    logic [SB-1:0] level;
    logic          last;
  } widened_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SB-1:0] sample_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SB-1:0] sample_out_o;
  logic frame_last_o;

  logic signed [SB-1:0] sample_queue[$];
  widened_t widened_queue[$];

  // frame buffer of the predictor
  longint frame_buf[MAX_CH];
  int buf_fill = 0;
  longint buf_sum = 0;
  logic [CC_W-1:0] cur_channels = CC_RESET;
  logic [GAIN_W-1:0] cur_gain = GAIN_RESET;

  int burst_left = 0;
  int gap_left = 0;
  int stall_run = 0;
  bit stall_now = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  int mismatches = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int holds_done = 0;
  int cycle_count = 0;

  channel_difference_amplify_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .frame_last_o(frame_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int active_channels(logic [CC_W-1:0] cc);
    if (cc == 0) return 1;
    if (cc > MAX_CH) return MAX_CH;
    return int'(cc);
  endfunction

  // buffer one sample; at frame end widen every channel around the mean
  task automatic take_sample(input logic signed [SB-1:0] s);
    int n;
    int k;
    longint mean;
    longint diff;
    longint prod;
    longint r;
    widened_t w;
    n = active_channels(cur_channels);
    if (buf_fill >= n) begin
      buf_fill = 0;
      buf_sum = 0;
    end
    frame_buf[buf_fill] = longint'(s);
    buf_sum = buf_sum + longint'(s);
    buf_fill++;
    if (buf_fill == n) begin
      if (buf_sum >= 0) mean = buf_sum / n;
      else mean = -((-buf_sum + n - 1) / n);
      for (k = 0; k < n; k++) begin
        diff = frame_buf[k] - mean;
        prod = diff * longint'({48'd0, cur_gain});
        r = mean + (prod >>> GAIN_FRAC);
        if (r > L_MAX) r = L_MAX;
        if (r < L_MIN) r = L_MIN;
        w.level = r[SB-1:0];
        w.last = (k == n - 1);
        widened_queue.push_back(w);
      end
      buf_fill = 0;
      buf_sum = 0;
    end
  endtask

  // driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_in_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        take_sample(sample_in_i);
        samples_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_valid_i <= 1'b1;
          sample_in_i <= sample_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each item, stall on a pattern of its own
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (widened_queue.size() == 0) begin
          $display("%0t: unexpected item sample_out %0d frame_last %0b", $time,
                   sample_out_o, frame_last_o);
          mismatches++;
        end else begin
          widened_t w;
          w = widened_queue.pop_front();
          if (sample_out_o !== w.level) begin
            $display("%0t: sample_out expected %0d actual %0d", $time,
                     $signed(w.level), sample_out_o);
            mismatches++;
          end
          if (frame_last_o !== w.last) begin
            $display("%0t: frame_last expected %0b actual %0b", $time, w.last,
                     frame_last_o);
            mismatches++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (stall_run == 0) begin
          stall_now = ~stall_now;
          if (stall_now) stall_run = $urandom_range(1, 6);
          else if ($urandom_range(0, 3) == 0) stall_run = $urandom_range(20, 60);
          else stall_run = $urandom_range(1, 8);
        end
        stall_run--;
        out_stall_i <= stall_now;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d items outstanding", $time,
               cycle_count, widened_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT: begin
        cur_channels = data[CC_W-1:0];
        buf_fill = 0;
        buf_sum = 0;
      end
      REG_WIDTH_GAIN: cur_gain = data[GAIN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
  endtask

  // wait until every item is out, then let the back end go quiet
  task automatic drain_and_rest();
    @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || widened_queue.size() != 0)
      @(negedge clk_i);
    repeat (REST_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [SB-1:0] pick_sample();
    logic signed [SB-1:0] v;
    case ($urandom_range(0, 7))
      0: v = S_MAX;
      1: v = S_MIN;
      2: begin
        v = SB'($urandom_range(0, 512));
        v = v - SB'(256);
      end
      default: v = SB'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    int random_items;
    int n;
    int frames;
    int i;
    int phase;
    logic [CFG_DATA_W-1:0] cc_data;
    logic [CFG_DATA_W-1:0] gain_data;

    random_items = 0;
    phase = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // reset settings: two channels, unity gain
    sample_queue.push_back(S_MAX);
    sample_queue.push_back(S_MIN);
    sample_queue.push_back('0);
    sample_queue.push_back('1);
    drain_and_rest();

    write_reg(REG_WIDTH_GAIN, 16'hFFFF);
    sample_queue.push_back(S_MAX);
    sample_queue.push_back(S_MIN);
    sample_queue.push_back(24'sd100);
    sample_queue.push_back(-24'sd100);
    drain_and_rest();

    // zero channels acts as one: samples pass unchanged
    write_reg(REG_CHANNEL_COUNT, 16'h0000);
    sample_queue.push_back(S_MAX);
    sample_queue.push_back(S_MIN);
    sample_queue.push_back('1);
    drain_and_rest();

    // oversized count clamps to the maximum; zero gain gives the mean
    write_reg(REG_CHANNEL_COUNT, 16'hFFFF);
    write_reg(REG_WIDTH_GAIN, 16'h0000);
    repeat (4) sample_queue.push_back(S_MAX);
    sample_queue.push_back(S_MIN);
    sample_queue.push_back(24'sd1);
    sample_queue.push_back('1);
    sample_queue.push_back('0);
    drain_and_rest();

    // partial frame dropped by rewriting the same count
    write_reg(REG_CHANNEL_COUNT, 16'hFFF3);
    write_reg(REG_WIDTH_GAIN, 16'd8192);
    sample_queue.push_back(S_MAX);
    sample_queue.push_back(S_MAX);
    drain_and_rest();
    write_reg(REG_CHANNEL_COUNT, 16'd3);
    sample_queue.push_back(S_MIN);
    sample_queue.push_back(24'sd5000);
    sample_queue.push_back(-24'sd7);
    drain_and_rest();

    // gain change with a sample buffered
    write_reg(REG_CHANNEL_COUNT, 16'd2);
    sample_queue.push_back(S_MIN);
    drain_and_rest();
    write_reg(REG_WIDTH_GAIN, 16'd12288);
    sample_queue.push_back(S_MAX);
    drain_and_rest();

    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        cc_data = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 9))
          0: cc_data[CC_W-1:0] = CC_W'(0);
          1: cc_data[CC_W-1:0] = CC_W'($urandom_range(MAX_CH + 1, 15));
          default: cc_data[CC_W-1:0] = CC_W'($urandom_range(1, MAX_CH));
        endcase
        if (phase == 0) cc_data[CC_W-1:0] = CC_W'(4);
        write_reg(REG_CHANNEL_COUNT, cc_data);
      end
      case ($urandom_range(0, 5))
        0: gain_data = 16'h0000;
        1: gain_data = 16'hFFFF;
        2: gain_data = GAIN_RESET;
        3: gain_data = CFG_DATA_W'($urandom_range(0, 8191));
        default: gain_data = CFG_DATA_W'($urandom);
      endcase
      write_reg(REG_WIDTH_GAIN, gain_data);
      n = active_channels(cur_channels);
      frames = $urandom_range(1, 6);
      // hold the output long enough for both frame banks to fill
      if (phase == 0) begin
        frames = 12;
        hold_request = 1'b1;
      end
      for (i = 0; i < frames * n; i++) sample_queue.push_back(pick_sample());
      random_items += frames * n;
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, n - 1)) sample_queue.push_back(pick_sample());
      end
      drain_and_rest();
      phase++;
    end

    drain_and_rest();
    $display("covered %0d samples, %0d results, %0d register writes, %0d phases",
             samples_sent, results_seen, reg_writes, phase);
    $display("long output holds: %0d, mismatches: %0d", holds_done, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
